// ----- rtl/rrb_pkg.sv -----
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared types and constants for the record ring buffer.
// ----------------------------------------------------------------------------
package rrb_pkg;

  localparam int unsigned DEF_BUFFER_BYTES    = 4096;
  localparam int unsigned DEF_PRIORITY_OFFSET = 12;
  localparam int unsigned PREFIX_BYTES        = 4;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_APPEND = 2'd1,
    OP_FETCH  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_REJECTED = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FOUND    = 3'd3,
    ST_BYTE     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BEGIN,
    S_APPEND,
    S_FETCH,
    S_HDR,
    S_LEN,
    S_SPAN,
    S_PRIO,
    S_DECIDE,
    S_PREFIX,
    S_READ,
    S_READ_WAIT
  } seq_state_t;

endpackage

// ----- rtl/rrb_ram.sv -----
// ----------------------------------------------------------------------------
// rrb_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module rrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/record_ring_buffer_drop_oldest.sv -----
// ----------------------------------------------------------------------------
// record_ring_buffer_drop_oldest
// Byte ring of length-prefixed records that evicts the oldest records.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Each command
// gives exactly one result word, shown for one cycle with out_valid high;
// the receiver cannot stall it. busy stays high until that result cycle.
// Steps from acceptance to result:
//   append: one state writes the byte. read byte: one memory read, then
//   the registered read data is returned. begin: a check, then per evicted
//   record a two-byte length read through the single read port and the
//   pointer update, then the four prefix bytes are written. fetch: an empty
//   check, then per record a length read and a four-byte priority read.
// All record state sits in one byte RAM; the pointers and counters are
// flip-flops. Reset clears the pointers and counters; the RAM is
// not cleared, since no entry is read before it has been written.
// ----------------------------------------------------------------------------
module record_ring_buffer_drop_oldest #(
  parameter int unsigned BUFFER_BYTES    = rrb_pkg::DEF_BUFFER_BYTES,
  parameter int unsigned PRIORITY_OFFSET = rrb_pkg::DEF_PRIORITY_OFFSET
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [11:0] in_record_length,
  input  logic [7:0]  in_data_byte,
  input  logic [2:0]  in_min_priority,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [11:0] out_found_length,
  output logic [7:0]  out_read_byte,
  output logic        out_last_byte
);

  import rrb_pkg::*;

  localparam int unsigned PW = $clog2(BUFFER_BYTES);
  localparam int unsigned UW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned CW = (UW > 13) ? UW : 13;
  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] BUF_S  = SW'(BUFFER_BYTES);
  localparam logic [SW-1:0] PRIO_S = SW'(PREFIX_BYTES + PRIORITY_OFFSET);
  localparam logic [12:0]  MIN_LEN = 13'(PRIORITY_OFFSET + 4);

  function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = (s >= BUF_S) ? (s - BUF_S) : s;
    return t[PW-1:0];
  endfunction

  seq_state_t state_r, state_nxt;
  logic [11:0] rlen_r, rlen_nxt;
  logic [7:0]  dbyte_r, dbyte_nxt;
  logic [2:0]  minp_r, minp_nxt;
  logic [PW-1:0] rp_r, rp_nxt, wp_r, wp_nxt, addr_r, addr_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic [11:0] app_r, app_nxt, rrem_r, rrem_nxt, len_r, len_nxt;
  logic [CW-1:0] span_r, span_nxt;
  logic [31:0] pw_r, pw_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        fetch_r, fetch_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [11:0] flen_r, flen_nxt;
  logic [7:0]  rbyte_r, rbyte_nxt;
  logic        last_r, last_nxt;

  logic          wr_en;
  logic [PW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  logic          cons_en;
  logic [CW-1:0] cons_n, cons_c, used_c;
  logic [12:0]   need;
  logic [SW-1:0] fill_sum;
  logic          no_room;
  logic [CW-1:0] len4;

  rrb_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign used_c   = CW'(used_r);
  assign need     = {1'b0, rlen_r} + 13'(PREFIX_BYTES);
  assign fill_sum = SW'(used_r) + SW'(need);
  assign no_room  = fill_sum > BUF_S;
  assign len4     = CW'(len_r) + CW'(PREFIX_BYTES);

  always_comb begin
    state_nxt = state_r; rlen_nxt = rlen_r; dbyte_nxt = dbyte_r;
    minp_nxt = minp_r; rp_nxt = rp_r; wp_nxt = wp_r; addr_nxt = addr_r;
    used_nxt = used_r; app_nxt = app_r; rrem_nxt = rrem_r; len_nxt = len_r;
    span_nxt = span_r; pw_nxt = pw_r; cnt_nxt = cnt_r; fetch_nxt = fetch_r;
    out_valid_nxt = 1'b0; status_nxt = status_r; flen_nxt = flen_r;
    rbyte_nxt = rbyte_r; last_nxt = last_r;
    wr_en = 1'b0; wr_addr = wp_r; wr_data = 8'd0; rd_addr = addr_r;
    cons_en = 1'b0; cons_n = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          rlen_nxt = in_record_length;
          dbyte_nxt = in_data_byte;
          minp_nxt = in_min_priority;
          unique case (op_t'(in_operation))
            OP_BEGIN:  state_nxt = S_BEGIN;
            OP_APPEND: state_nxt = S_APPEND;
            OP_FETCH:  state_nxt = S_FETCH;
            OP_READ:   state_nxt = S_READ;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_BEGIN: begin
        if (app_r != 12'd0 || SW'(need) > BUF_S || {1'b0, rlen_r} < MIN_LEN) begin
          out_valid_nxt = 1'b1; status_nxt = ST_REJECTED; flen_nxt = '0;
          rbyte_nxt = '0; last_nxt = 1'b0; state_nxt = S_IDLE;
        end else begin
          if (no_room && rrem_r != 12'd0) begin
            cons_en = 1'b1; cons_n = CW'(rrem_r); rrem_nxt = '0;
          end
          fetch_nxt = 1'b0;
          state_nxt = S_HDR;
        end
      end
      S_APPEND: begin
        out_valid_nxt = 1'b1; flen_nxt = '0; rbyte_nxt = '0; last_nxt = 1'b0;
        state_nxt = S_IDLE;
        if (app_r != 12'd0) begin
          wr_en = 1'b1; wr_data = dbyte_r;
          wp_nxt = wrap(SW'(wp_r) + SW'(1));
          app_nxt = app_r - 12'd1;
          status_nxt = ST_ACCEPTED;
        end else begin
          status_nxt = ST_REJECTED;
        end
      end
      S_FETCH: begin
        cons_en = 1'b1; cons_n = CW'(rrem_r); rrem_nxt = '0;
        fetch_nxt = 1'b1;
        state_nxt = S_HDR;
      end
      S_HDR: begin
        addr_nxt = rp_r; cnt_nxt = '0;
        if (fetch_r) begin
          if (used_r == '0) begin
            out_valid_nxt = 1'b1; status_nxt = ST_EMPTY; flen_nxt = '0;
            rbyte_nxt = '0; last_nxt = 1'b0; state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LEN;
          end
        end else if (!no_room || used_r == '0) begin
          state_nxt = S_PREFIX;
        end else begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        // The two low bytes of the prefix carry the whole 12-bit length.
        addr_nxt = wrap(SW'(addr_r) + SW'(1));
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd1) len_nxt[7:0] = rd_data;
        if (cnt_r == 3'd2) begin
          len_nxt[11:8] = rd_data[3:0];
          state_nxt = S_SPAN;
        end
      end
      S_SPAN: begin
        if (len4 > used_c) begin
          span_nxt = used_c;
          len_nxt = (used_c >= CW'(PREFIX_BYTES)) ? 12'(used_c - CW'(PREFIX_BYTES)) : 12'd0;
        end else begin
          span_nxt = len4;
        end
        if (!fetch_r) begin
          cons_en = 1'b1;
          cons_n = (len4 > used_c) ? used_c : len4;
          state_nxt = S_HDR;
        end else if (app_r != 12'd0 && (len4 >= used_c)) begin
          // The record at the head is still being filled.
          out_valid_nxt = 1'b1; status_nxt = ST_EMPTY; flen_nxt = '0;
          rbyte_nxt = '0; last_nxt = 1'b0; state_nxt = S_IDLE;
        end else begin
          addr_nxt = wrap(SW'(rp_r) + PRIO_S);
          cnt_nxt = '0;
          state_nxt = S_PRIO;
        end
      end
      S_PRIO: begin
        addr_nxt = wrap(SW'(addr_r) + SW'(1));
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r != 3'd0) pw_nxt = {rd_data, pw_r[31:8]};
        if (cnt_r == 3'd4) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cons_en = 1'b1;
        if (!pw_r[31] && pw_r >= 32'(minp_r)) begin
          cons_n = CW'(PREFIX_BYTES);
          rrem_nxt = len_r;
          out_valid_nxt = 1'b1; status_nxt = ST_FOUND; flen_nxt = len_r;
          rbyte_nxt = '0; last_nxt = 1'b0; state_nxt = S_IDLE;
        end else begin
          cons_n = span_r;
          state_nxt = S_HDR;
        end
      end
      S_PREFIX: begin
        wr_en = 1'b1;
        wr_data = (cnt_r == 3'd0) ? rlen_r[7:0] :
                  (cnt_r == 3'd1) ? {4'd0, rlen_r[11:8]} : 8'd0;
        wp_nxt = wrap(SW'(wp_r) + SW'(1));
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          used_nxt = UW'(fill_sum);
          app_nxt = rlen_r;
          out_valid_nxt = 1'b1; status_nxt = ST_ACCEPTED; flen_nxt = '0;
          rbyte_nxt = '0; last_nxt = 1'b0; state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        rd_addr = rp_r;
        if (rrem_r != 12'd0 && used_r != '0) begin
          state_nxt = S_READ_WAIT;
        end else begin
          rrem_nxt = '0;
          out_valid_nxt = 1'b1; status_nxt = ST_EMPTY; flen_nxt = '0;
          rbyte_nxt = '0; last_nxt = 1'b0; state_nxt = S_IDLE;
        end
      end
      S_READ_WAIT: begin
        cons_en = 1'b1; cons_n = CW'(1);
        rrem_nxt = rrem_r - 12'd1;
        out_valid_nxt = 1'b1; status_nxt = ST_BYTE; flen_nxt = '0;
        rbyte_nxt = rd_data; last_nxt = (rrem_r == 12'd1);
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // Remove bytes at the read side, never more than are in use.
    cons_c = (cons_n > used_c) ? used_c : cons_n;
    if (cons_en) begin
      rp_nxt = wrap(SW'(rp_r) + SW'(cons_c));
      used_nxt = UW'(used_c - cons_c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rp_r <= '0;
      wp_r <= '0;
      used_r <= '0;
      app_r <= '0;
      rrem_r <= '0;
      cnt_r <= '0;
      fetch_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rp_r <= rp_nxt;
      wp_r <= wp_nxt;
      used_r <= used_nxt;
      app_r <= app_nxt;
      rrem_r <= rrem_nxt;
      cnt_r <= cnt_nxt;
      fetch_r <= fetch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rlen_r <= rlen_nxt;
    dbyte_r <= dbyte_nxt;
    minp_r <= minp_nxt;
    addr_r <= addr_nxt;
    len_r <= len_nxt;
    span_r <= span_nxt;
    pw_r <= pw_nxt;
    status_r <= status_nxt;
    flen_r <= flen_nxt;
    rbyte_r <= rbyte_nxt;
    last_r <= last_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_found_length = flen_r;
  assign out_read_byte    = rbyte_r;
  assign out_last_byte    = last_r;

endmodule

// ----- rtl/rrb_checker.sv -----
// ----------------------------------------------------------------------------
// rrb_checker
// Port-level assertions for the record ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module rrb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [11:0] out_found_length,
  input logic [7:0]  out_read_byte,
  input logic        out_last_byte
);

  import rrb_pkg::*;

  // Every accepted command makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted command left busy low");

  // A result word is a single-cycle strobe.
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");

  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FOUND |-> out_found_length == 12'd0)
    else $error("found length set on a result that is not a found record");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_BYTE |-> out_read_byte == 8'd0 && !out_last_byte)
    else $error("byte fields set on a result that gives no byte");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid) else $error("activity right after reset");

endmodule

bind record_ring_buffer_drop_oldest rrb_checker u_rrb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_found_length (out_found_length),
  .out_read_byte    (out_read_byte),
  .out_last_byte    (out_last_byte)
);
